FILE: rtl/dnsrap_pkg.sv
package dnsrap_pkg;

  // parser phases
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_NAME    = 3'd1;
  localparam logic [2:0] PH_POINTER = 3'd2;
  localparam logic [2:0] PH_QFIXED  = 3'd3;
  localparam logic [2:0] PH_AFIXED  = 3'd4;
  localparam logic [2:0] PH_ADATA   = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;

  // result codes
  localparam logic [1:0] OUT_FOUND = 2'd0;
  localparam logic [1:0] OUT_BAD   = 2'd1;
  localparam logic [1:0] OUT_NONE  = 2'd2;

  localparam logic [7:0]  MAX_LABELS  = 8'd128;
  localparam logic [15:0] FLAGS_MASK  = 16'h800f;
  localparam logic [15:0] FLAGS_OK    = 16'h8000;
  localparam logic [15:0] TYPE_A      = 16'd1;
  localparam logic [15:0] CLASS_IN    = 16'd1;
  localparam logic [15:0] ADDR_LEN    = 16'd4;
  localparam logic [7:0]  LABELS_SAT  = 8'hff;
  localparam logic [1:0]  PTR_TAG     = 2'b11;
  localparam logic [1:0]  LABEL_TAG   = 2'b00;

  // header byte positions
  localparam logic [3:0] HP_ID_LO    = 4'd1;
  localparam logic [3:0] HP_FLAGS_LO = 4'd3;
  localparam logic [3:0] HP_QD_LO    = 4'd5;
  localparam logic [3:0] HP_AN_LO    = 4'd7;
  localparam logic [3:0] HP_LAST     = 4'd11;

  // fixed field positions
  localparam logic [3:0] QF_LAST     = 4'd3;
  localparam logic [3:0] AF_CLASS    = 4'd2;
  localparam logic [3:0] AF_TTL      = 4'd4;
  localparam logic [3:0] AF_RDLEN    = 4'd8;
  localparam logic [3:0] AF_LAST     = 4'd9;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  outcome;
    logic [31:0] address;
  } result_t;

endpackage

FILE: rtl/dns_response_address_parser.sv
// path: a packet byte is taken into the input register and parsed from there; its result, if any,
//   is then registered in the result register before it is shown
// throughput: one packet byte per cycle while the result register is not stalled
// reset: rst_ni is asynchronous and active low; clears the expected identifier, the
//   parser state and both pipeline valid bits
module dns_response_address_parser import dnsrap_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: expected query identifier
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_expected_id_i,
  // packet bytes in
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  packet_byte_i,
  input  logic        final_byte_i,
  // result beats out
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  outcome_o,
  output logic [31:0] address_o
);

  beat_t   beat;
  result_t result;
  logic    out_free;
  logic    fire;

  // the register write is always taken; the user writes only while the block is idle, unchecked
  assign cfg_ready_o = 1'b1;

  // a registered byte is parsed once the result register has room for whatever it causes
  assign fire = beat.valid && out_free;

  // input register, holds the byte while the result side is stalled
  dnsrap_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .packet_byte_i (packet_byte_i),
    .final_byte_i  (final_byte_i),
    .take_i        (fire),
    .beat_o        (beat)
  );

  // header check, name skipping and record walk, one byte per fire
  dnsrap_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_expected_id_i),
    .fire_i     (fire),
    .beat_i     (beat),
    .result_o   (result)
  );

  // result register, one beat per packet at most
  dnsrap_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .result_i    (result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .outcome_o   (outcome_o),
    .address_o   (address_o)
  );

  // a waiting result is never overwritten by a new parse
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> !fire)
    else $error("parser fired into a stalled result register");

  // a byte held in the input register stays until it is parsed
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat.valid && !fire |=> beat.valid && $stable(beat.data) && $stable(beat.last))
    else $error("held packet byte lost or changed");

  // only a found address carries a nonzero address
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o != OUT_FOUND |-> address_o == '0)
    else $error("address nonzero on a result without an address");

endmodule

FILE: rtl/dnsrap_in_stage.sv
module dnsrap_in_stage import dnsrap_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] packet_byte_i,
  input  logic       final_byte_i,
  input  logic       take_i,
  output beat_t      beat_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       last_q;
  logic       load;

  always_comb begin
    in_stall_o = valid_q && !take_i;
    load       = !in_stall_o;
    valid_d    = load ? in_valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      data_q <= packet_byte_i;
      last_q <= final_byte_i;
    end
  end

  assign beat_o = '{valid: valid_q, data: data_q, last: last_q};

endmodule

FILE: rtl/dnsrap_parser.sv
module dnsrap_parser import dnsrap_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        fire_i,
  input  beat_t       beat_i,
  output result_t     result_o
);

  logic [15:0] expected_id_q;

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  hpos_q, hpos_d;
  logic [15:0] hword_q, hword_d;
  logic [15:0] qleft_q, qleft_d;
  logic [15:0] aleft_q, aleft_d;
  logic [7:0]  labels_q, labels_d;
  logic [5:0]  lbytes_q, lbytes_d;
  logic [3:0]  fpos_q, fpos_d;
  logic [15:0] rtype_q, rtype_d;
  logic [15:0] rclass_q, rclass_d;
  logic [15:0] dleft_q, dleft_d;
  logic [31:0] acc_q, acc_d;
  logic        given_q, given_d;

  logic        emit;
  logic [1:0]  code;
  logic [31:0] addr;

  always_comb begin
    logic [7:0]  b;
    logic [15:0] hw_new;
    logic [15:0] dl_new;
    logic        more;

    b        = beat_i.data;
    phase_d  = phase_q;
    hpos_d   = hpos_q;
    hword_d  = hword_q;
    qleft_d  = qleft_q;
    aleft_d  = aleft_q;
    labels_d = labels_q;
    lbytes_d = lbytes_q;
    fpos_d   = fpos_q;
    rtype_d  = rtype_q;
    rclass_d = rclass_q;
    dleft_d  = dleft_q;
    acc_d    = acc_q;
    given_d  = given_q;
    emit     = 1'b0;
    code     = OUT_BAD;
    addr     = '0;
    hw_new   = '0;
    dl_new   = {dleft_q[7:0], b};
    more     = 1'b0;

    // the last length byte of an answer also lands in the header word
    if (phase_q == PH_AFIXED && fpos_q == AF_LAST) begin
      hword_d = dl_new;
    end

    unique case (phase_q)
      PH_HEADER: begin
        hw_new  = {hword_q[7:0], b};
        hword_d = hw_new;
        if (hpos_q == HP_ID_LO && hw_new != expected_id_q) begin
          emit = 1'b1;
        end else if (hpos_q == HP_FLAGS_LO && (hw_new & FLAGS_MASK) != FLAGS_OK) begin
          emit = 1'b1;
        end else begin
          if (hpos_q == HP_QD_LO) qleft_d = hw_new;
          if (hpos_q == HP_AN_LO) aleft_d = hw_new;
          if (hpos_q >= HP_LAST) begin
            more = (qleft_q != '0) || (aleft_q != '0);
            if (!more) begin
              emit = 1'b1;
              code = OUT_NONE;
            end
          end else begin
            hpos_d = hpos_q + 4'd1;
          end
        end
      end
      PH_NAME: begin
        if (lbytes_q != '0) begin
          lbytes_d = lbytes_q - 6'd1;
          if (lbytes_q == 6'd1 && labels_q >= MAX_LABELS) emit = 1'b1;
        end else if (b == 8'd0) begin
          fpos_d  = '0;
          phase_d = (qleft_q != '0) ? PH_QFIXED : PH_AFIXED;
        end else if (b[7:6] == PTR_TAG) begin
          phase_d = PH_POINTER;
        end else if (b[7:6] != LABEL_TAG) begin
          emit = 1'b1;
        end else begin
          labels_d = labels_q + 8'd1;
          lbytes_d = b[5:0];
        end
      end
      PH_POINTER: begin
        fpos_d  = '0;
        phase_d = (qleft_q != '0) ? PH_QFIXED : PH_AFIXED;
      end
      PH_QFIXED: begin
        if (fpos_q < QF_LAST) begin
          fpos_d = fpos_q + 4'd1;
        end else begin
          qleft_d = qleft_q - 16'd1;
          more    = (qleft_d != '0) || (aleft_q != '0);
          if (!more) begin
            emit = 1'b1;
            code = OUT_NONE;
          end
        end
      end
      PH_AFIXED: begin
        if (fpos_q < AF_CLASS) begin
          rtype_d = {rtype_q[7:0], b};
        end else if (fpos_q < AF_TTL) begin
          rclass_d = {rclass_q[7:0], b};
        end else if (fpos_q >= AF_RDLEN) begin
          dleft_d = dl_new;
        end
        if (fpos_q < AF_LAST) begin
          fpos_d = fpos_q + 4'd1;
        end else begin
          acc_d = '0;
          if (dl_new != '0) begin
            phase_d = PH_ADATA;
          end else begin
            aleft_d = aleft_q - 16'd1;
            more    = (qleft_q != '0) || (aleft_d != '0);
            if (!more) begin
              emit = 1'b1;
              code = OUT_NONE;
            end
          end
        end
      end
      PH_ADATA: begin
        acc_d   = {acc_q[23:0], b};
        dleft_d = dleft_q - 16'd1;
        if (dleft_d == '0) begin
          aleft_d = aleft_q - 16'd1;
          if (rtype_q == TYPE_A && rclass_q == CLASS_IN && labels_q != LABELS_SAT
              && hword_q == ADDR_LEN) begin
            emit = 1'b1;
            code = OUT_FOUND;
            addr = acc_d;
          end else begin
            more = (qleft_q != '0) || (aleft_d != '0);
            if (!more) begin
              emit = 1'b1;
              code = OUT_NONE;
            end
          end
        end
      end
      default: begin
      end
    endcase

    // a new record starts with a fresh name
    if (more) begin
      phase_d  = PH_NAME;
      labels_d = '0;
      lbytes_d = '0;
    end

    // packet ends before any outcome: truncated
    if (beat_i.last && !emit && !given_q) begin
      emit = 1'b1;
      code = OUT_BAD;
      addr = '0;
    end

    if (emit) begin
      phase_d = PH_DONE;
      given_d = 1'b1;
    end

    if (beat_i.last) begin
      phase_d  = PH_HEADER;
      hpos_d   = '0;
      hword_d  = '0;
      qleft_d  = '0;
      aleft_d  = '0;
      labels_d = '0;
      lbytes_d = '0;
      fpos_d   = '0;
      rtype_d  = '0;
      rclass_d = '0;
      dleft_d  = '0;
      acc_d    = '0;
      given_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_id_q <= '0;
      phase_q       <= PH_HEADER;
      hpos_q        <= '0;
      hword_q       <= '0;
      qleft_q       <= '0;
      aleft_q       <= '0;
      labels_q      <= '0;
      lbytes_q      <= '0;
      fpos_q        <= '0;
      rtype_q       <= '0;
      rclass_q      <= '0;
      dleft_q       <= '0;
      acc_q         <= '0;
      given_q       <= 1'b0;
    end else begin
      if (cfg_we_i) expected_id_q <= cfg_data_i;
      if (fire_i) begin
        phase_q  <= phase_d;
        hpos_q   <= hpos_d;
        hword_q  <= hword_d;
        qleft_q  <= qleft_d;
        aleft_q  <= aleft_d;
        labels_q <= labels_d;
        lbytes_q <= lbytes_d;
        fpos_q   <= fpos_d;
        rtype_q  <= rtype_d;
        rclass_q <= rclass_d;
        dleft_q  <= dleft_d;
        acc_q    <= acc_d;
        given_q  <= given_d;
      end
    end
  end

  assign result_o = '{valid: fire_i && emit, outcome: code,
                      address: (code == OUT_FOUND) ? addr : '0};

endmodule

FILE: rtl/dnsrap_out_stage.sv
module dnsrap_out_stage import dnsrap_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  result_t     result_i,
  output logic        free_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  outcome_o,
  output logic [31:0] address_o
);

  logic        valid_q, valid_d;
  logic [1:0]  outcome_q;
  logic [31:0] address_q;

  always_comb begin
    free_o  = !valid_q || !out_stall_i;
    valid_d = valid_q;
    if (result_i.valid) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_i.valid) begin
      outcome_q <= result_i.outcome;
      address_q <= result_i.address;
    end
  end

  assign out_valid_o = valid_q;
  assign outcome_o   = outcome_q;
  assign address_o   = address_q;

endmodule

FILE: tb/sv/dns_answer_checker.sv
module dns_answer_checker
  import dnsrap_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_expected_id_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  packet_byte_i,
  input  logic        final_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  outcome_i,
  input  logic [31:0] address_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [31:0] address;
  } lookup_result_t;

  lookup_result_t answers_due[$];
  int             n_fail;

  // shadow of the parser
  logic [15:0] id_reg;
  logic [2:0]  ph;
  logic [3:0]  hdr_pos;
  logic [15:0] hdr_word;
  logic [15:0] qd_left;
  logic [15:0] an_left;
  logic [7:0]  lbl_cnt;
  logic [5:0]  lbl_left;
  logic [3:0]  fld_pos;
  logic [15:0] rec_type;
  logic [15:0] rec_class;
  logic [15:0] rd_left;
  logic [31:0] addr_acc;
  logic        outcome_sent;

  function automatic void clear_packet();
    ph           = PH_HEADER;
    hdr_pos      = '0;
    hdr_word     = '0;
    qd_left      = '0;
    an_left      = '0;
    lbl_cnt      = '0;
    lbl_left     = '0;
    fld_pos      = '0;
    rec_type     = '0;
    rec_class    = '0;
    rd_left      = '0;
    addr_acc     = '0;
    outcome_sent = 1'b0;
  endfunction

  function automatic void report_outcome(logic [1:0] code, logic [31:0] addr);
    lookup_result_t r;
    r.outcome = code;
    r.address = (code == OUT_FOUND) ? addr : 32'd0;
    answers_due.push_back(r);
    ph           = PH_DONE;
    outcome_sent = 1'b1;
  endfunction

  // returns 1 when another question or answer record follows
  function automatic bit start_next_record();
    if (qd_left != 16'd0 || an_left != 16'd0) begin
      ph       = PH_NAME;
      lbl_cnt  = '0;
      lbl_left = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void close_name();
    fld_pos = '0;
    ph      = (qd_left != 16'd0) ? PH_QFIXED : PH_AFIXED;
  endfunction

  function automatic void parse_packet_byte(logic [7:0] b, logic fin);
    // data length snoop on the last fixed byte of an answer
    if (ph == PH_AFIXED && fld_pos == AF_LAST) hdr_word = {rd_left[7:0], b};
    case (ph)
      PH_HEADER: begin
        hdr_word = {hdr_word[7:0], b};
        if (hdr_pos == HP_ID_LO && hdr_word != id_reg) begin
          report_outcome(OUT_BAD, 32'd0);
        end else if (hdr_pos == HP_FLAGS_LO && (hdr_word & FLAGS_MASK) != FLAGS_OK) begin
          report_outcome(OUT_BAD, 32'd0);
        end else begin
          if (hdr_pos == HP_QD_LO) qd_left = hdr_word;
          if (hdr_pos == HP_AN_LO) an_left = hdr_word;
          if (hdr_pos >= HP_LAST) begin
            if (!start_next_record()) report_outcome(OUT_NONE, 32'd0);
          end else begin
            hdr_pos = hdr_pos + 4'd1;
          end
        end
      end
      PH_NAME: begin
        if (lbl_left != '0) begin
          lbl_left = lbl_left - 6'd1;
          if (lbl_left == '0 && lbl_cnt >= MAX_LABELS) report_outcome(OUT_BAD, 32'd0);
        end else if (b == 8'h00) begin
          close_name();
        end else if (b[7:6] == PTR_TAG) begin
          ph = PH_POINTER;
        end else if (b[7:6] != LABEL_TAG) begin
          report_outcome(OUT_BAD, 32'd0);
        end else begin
          lbl_cnt  = lbl_cnt + 8'd1;
          lbl_left = b[5:0];
        end
      end
      PH_POINTER: begin
        close_name();
      end
      PH_QFIXED: begin
        if (fld_pos < QF_LAST) begin
          fld_pos = fld_pos + 4'd1;
        end else begin
          qd_left = qd_left - 16'd1;
          if (!start_next_record()) report_outcome(OUT_NONE, 32'd0);
        end
      end
      PH_AFIXED: begin
        if (fld_pos < AF_CLASS) rec_type = {rec_type[7:0], b};
        else if (fld_pos < AF_TTL) rec_class = {rec_class[7:0], b};
        else if (fld_pos >= AF_RDLEN) rd_left = {rd_left[7:0], b};
        if (fld_pos < AF_LAST) begin
          fld_pos = fld_pos + 4'd1;
        end else begin
          addr_acc = '0;
          if (rd_left != 16'd0) begin
            ph = PH_ADATA;
          end else begin
            an_left = an_left - 16'd1;
            if (!start_next_record()) report_outcome(OUT_NONE, 32'd0);
          end
        end
      end
      PH_ADATA: begin
        addr_acc = {addr_acc[23:0], b};
        rd_left  = rd_left - 16'd1;
        if (rd_left == 16'd0) begin
          an_left = an_left - 16'd1;
          if (rec_type == TYPE_A && rec_class == CLASS_IN && lbl_cnt != LABELS_SAT
              && hdr_word == ADDR_LEN) begin
            report_outcome(OUT_FOUND, addr_acc);
          end else if (!start_next_record()) begin
            report_outcome(OUT_NONE, 32'd0);
          end
        end
      end
      default: begin
      end
    endcase
    if (fin) begin
      // truncated packet: nothing decided before the last byte
      if (!outcome_sent) report_outcome(OUT_BAD, 32'd0);
      clear_packet();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    lookup_result_t due;
    if (!rst_ni) begin
      id_reg = '0;
      clear_packet();
      answers_due.delete();
      n_fail = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (answers_due.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("unexpected result beat: outcome %0d address %h", outcome_i, address_i);
        end else begin
          due = answers_due.pop_front();
          if (outcome_i !== due.outcome || address_i !== due.address) begin
            n_fail++;
            if (n_fail <= 10)
              $display("mismatch: expected outcome %0d address %h, got outcome %0d address %h",
                       due.outcome, due.address, outcome_i, address_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) id_reg = cfg_expected_id_i;
      if (in_valid_i && !in_stall_i) parse_packet_byte(packet_byte_i, final_byte_i);
      fail_count_o <= n_fail;
      pending_o    <= answers_due.size();
    end
  end

endmodule

FILE: tb/sv/dns_response_address_parser_tb.sv
module dns_response_address_parser_tb import dnsrap_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // run limits, all in clock cycles
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 6;

  // record types besides the address record
  localparam logic [15:0] TYPE_CNAME = 16'd5;
  localparam logic [15:0] TYPE_AAAA  = 16'd28;
  // usual response flags: response, recursion desired and available, code 0
  localparam logic [15:0] FLAGS_STD  = 16'h8180;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        cfg_valid_i       = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_expected_id_i = '0;
  logic        in_valid_i        = 1'b0;
  logic        in_stall_o;
  logic [7:0]  packet_byte_i     = '0;
  logic        final_byte_i      = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i       = 1'b0;
  logic [1:0]  outcome_o;
  logic [31:0] address_o;

  int fail_count;
  int pending;

  // stimulus bookkeeping
  logic [7:0]  pkt[$];
  logic [15:0] cur_id     = '0;
  int          sent_bytes = 0;
  int          rand_pkts  = 0;
  int          n_phase    = 0;
  bit          idle_en    = 1'b1;
  bit          hold_req   = 1'b0;
  bit          hold_done  = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  dns_response_address_parser uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_expected_id_i (cfg_expected_id_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .packet_byte_i     (packet_byte_i),
    .final_byte_i      (final_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .outcome_o         (outcome_o),
    .address_o         (address_o)
  );

  // predicts every result beat and scores what comes out
  dns_answer_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_expected_id_i (cfg_expected_id_i),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .packet_byte_i     (packet_byte_i),
    .final_byte_i      (final_byte_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .outcome_i         (outcome_o),
    .address_i         (address_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  // ---------------------------------------------------------------
  // packet building, bytes go into pkt in wire order
  // ---------------------------------------------------------------

  function automatic void push16(logic [15:0] v);
    pkt.push_back(v[15:8]);
    pkt.push_back(v[7:0]);
  endfunction

  // identifier, flags, question and answer counts, then random authority
  // and additional counts that the parser never looks at
  function automatic void add_header(logic [15:0] id, logic [15:0] flags,
                                     logic [15:0] qd, logic [15:0] an);
    push16(id);
    push16(flags);
    push16(qd);
    push16(an);
    push16(16'($urandom));
    push16(16'($urandom));
  endfunction

  function automatic void add_label(int len);
    pkt.push_back({LABEL_TAG, 6'(len)});
    repeat (len) pkt.push_back(8'($urandom));
  endfunction

  // compression pointer: tag byte plus one offset byte ends the name
  function automatic void add_pointer();
    pkt.push_back({PTR_TAG, 6'($urandom)});
    pkt.push_back(8'($urandom));
  endfunction

  // type, class, ttl and data length of an answer record
  function automatic void add_record_fields(logic [15:0] rtype, logic [15:0] rclass,
                                            logic [15:0] len);
    push16(rtype);
    push16(rclass);
    push16(16'($urandom));
    push16(16'($urandom));
    push16(len);
  endfunction

  function automatic void add_rdata(int len);
    repeat (len) pkt.push_back(8'($urandom));
  endfunction

  function automatic void add_random_name();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 3) begin
      pkt.push_back(8'h00);
    end else if (pick < 7) begin
      add_pointer();
    end else if (pick == 7) begin
      // length byte with a reserved tag
      pkt.push_back({($urandom_range(0, 1) ? 2'b01 : 2'b10), 6'($urandom)});
    end else begin
      repeat ($urandom_range(1, 3))
        add_label(($urandom_range(0, 24) == 0) ? 63 : $urandom_range(1, 10));
      if ($urandom_range(0, 2) == 0) add_pointer();
      else pkt.push_back(8'h00);
    end
  endfunction

  function automatic void add_random_answer();
    int          pick;
    int          len;
    logic [15:0] rtype;
    logic [15:0] rclass;
    pick   = $urandom_range(0, 9);
    rtype  = (pick < 6) ? TYPE_A : (pick == 6) ? TYPE_CNAME :
             (pick == 7) ? TYPE_AAAA : 16'($urandom);
    rclass = ($urandom_range(0, 7) == 0) ? 16'($urandom) : CLASS_IN;
    // address records mostly carry the right length, sometimes not
    if (rtype == TYPE_A && rclass == CLASS_IN && $urandom_range(0, 4) != 0) len = 4;
    else len = $urandom_range(0, 6);
    add_random_name();
    add_record_fields(rtype, rclass, 16'(len));
    add_rdata(len);
  endfunction

  // mostly well formed responses with random content, some noise
  function automatic void add_random_packet();
    int          qd;
    int          an;
    int          keep;
    logic [15:0] id;
    logic [15:0] flags;
    if ($urandom_range(0, 9) == 0) begin
      // raw noise
      repeat ($urandom_range(1, 20)) pkt.push_back(8'($urandom));
      return;
    end
    id    = ($urandom_range(0, 15) == 0) ? 16'($urandom) : cur_id;
    flags = {1'b1, 11'($urandom), 4'h0};
    if ($urandom_range(0, 11) == 0) flags = 16'($urandom);
    if ($urandom_range(0, 19) == 0) begin
      // wild counts, the packet runs out long before the records do
      add_header(id, flags, 16'($urandom), 16'($urandom));
      add_rdata($urandom_range(0, 8));
      return;
    end
    qd = $urandom_range(0, 2);
    an = $urandom_range(0, 3);
    add_header(id, flags, 16'(qd), 16'(an));
    repeat (qd) begin
      add_random_name();
      push16(16'($urandom));
      push16(16'($urandom));
    end
    repeat (an) add_random_answer();
    if ($urandom_range(0, 3) == 0) add_rdata($urandom_range(1, 4));
    if ($urandom_range(0, 7) == 0) begin
      keep = $urandom_range(1, pkt.size());
      while (pkt.size() > keep) void'(pkt.pop_back());
    end
  endfunction

  // ---------------------------------------------------------------
  // channel drivers
  // ---------------------------------------------------------------

  // sends pkt one beat per byte, the flag on the last one
  task automatic send_packet();
    int gap_odds;
    if (pkt.size() == 0) pkt.push_back(8'($urandom));
    // some packets go out back to back, others with random gaps
    gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 5);
    for (int i = 0; i < pkt.size(); i++) begin
      if (idle_en && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      in_valid_i    <= 1'b1;
      packet_byte_i <= pkt[i];
      final_byte_i  <= (i == pkt.size() - 1);
      do @(posedge clk_i); while (in_stall_o);
    end
    sent_bytes += pkt.size();
    pkt.delete();
  endtask

  // sender pause: every predicted result beat must have come out
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    // the checker books the last beat at the edge it was taken
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // beats that decide nothing may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_expected_id(logic [15:0] id);
    cfg_valid_i       <= 1'b1;
    cfg_expected_id_i <= id;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_id = id;
  endtask

  // ---------------------------------------------------------------
  // receiver: random stall bursts in busy stretches, one long hold-off
  // ---------------------------------------------------------------

  initial begin : sink_ctrl
    int span;
    bit busy;
    span = 0;
    busy = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        // long hold-off so the result path backs up into the input
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_done = 1'b1;
      end else if (idle_en && busy && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
      // alternate calm and busy stretches
      if (span == 0) begin
        span = $urandom_range(20, 80);
        busy = ($urandom_range(0, 2) != 0);
      end else begin
        span--;
      end
    end
  end

  // ---------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_expected_id(16'h0000);

    // identifier mismatch, decided on the second byte
    add_header(16'h0001, FLAGS_STD, 16'd1, 16'd1);
    send_packet();
    // two-byte packet whose mismatch falls on the final byte
    pkt.push_back(8'hff);
    pkt.push_back(8'hff);
    send_packet();
    // query bit clear
    add_header(16'h0000, 16'h0100, 16'd0, 16'd0);
    send_packet();
    // nonzero result code
    add_header(16'h0000, 16'h800f, 16'd0, 16'd0);
    send_packet();
    // no questions and no answers, trailing bytes ignored
    add_header(16'h0000, FLAGS_OK, 16'd0, 16'd0);
    pkt.push_back(8'hff);
    pkt.push_back(8'h00);
    send_packet();
    // a lone byte is a truncated header
    pkt.push_back(8'hff);
    send_packet();

    // address found through a pointer name, ends on the last address byte
    add_header(16'h0000, FLAGS_STD, 16'd1, 16'd1);
    add_label(3);
    add_label(3);
    pkt.push_back(8'h00);
    push16(TYPE_A);
    push16(CLASS_IN);
    add_pointer();
    add_record_fields(TYPE_A, CLASS_IN, ADDR_LEN);
    push16(16'hffff);
    push16(16'hffff);
    send_packet();

    // answers run out: wrong class, then an alias record
    add_header(16'h0000, FLAGS_STD, 16'd0, 16'd2);
    pkt.push_back(8'h00);
    add_record_fields(TYPE_A, 16'h00ff, ADDR_LEN);
    add_rdata(4);
    pkt.push_back(8'h00);
    add_record_fields(TYPE_CNAME, CLASS_IN, 16'd2);
    add_rdata(2);
    add_rdata(2);
    send_packet();

    // empty data, then wrong length, then the all-zero address
    add_header(16'h0000, FLAGS_STD, 16'd0, 16'd3);
    pkt.push_back(8'h00);
    add_record_fields(TYPE_A, CLASS_IN, 16'd0);
    pkt.push_back(8'h00);
    add_record_fields(TYPE_A, CLASS_IN, 16'd5);
    add_rdata(5);
    add_pointer();
    add_record_fields(TYPE_A, CLASS_IN, ADDR_LEN);
    push16(16'h0000);
    push16(16'h0000);
    add_rdata(1);
    send_packet();

    // reserved label tags in a question and in an answer name
    add_header(16'h0000, FLAGS_STD, 16'd1, 16'd0);
    pkt.push_back(8'h40);
    add_rdata(3);
    send_packet();
    add_header(16'h0000, FLAGS_STD, 16'd0, 16'd1);
    add_label(63);
    pkt.push_back(8'hbf);
    add_rdata(3);
    send_packet();

    // one label short of the limit is fine
    add_header(16'h0000, FLAGS_STD, 16'd1, 16'd0);
    repeat (MAX_LABELS - 1) add_label(1);
    pkt.push_back(8'h00);
    push16(TYPE_A);
    push16(CLASS_IN);
    send_packet();
    // at the label limit the name is rejected
    add_header(16'h0000, FLAGS_STD, 16'd1, 16'd0);
    repeat (MAX_LABELS) add_label(1);
    pkt.push_back(8'h00);
    push16(TYPE_A);
    push16(CLASS_IN);
    send_packet();

    // packet cut inside the address data
    add_header(16'h0000, FLAGS_STD, 16'd0, 16'd1);
    pkt.push_back(8'h00);
    add_record_fields(TYPE_A, CLASS_IN, ADDR_LEN);
    add_rdata(2);
    send_packet();

    // receiver holds off while short rejected packets keep coming
    wait_for_results();
    hold_req = 1'b1;
    repeat (12) begin
      push16(~cur_id);
      pkt.push_back(8'($urandom));
      send_packet();
    end

    // random phases, each under its own identifier
    while (sent_bytes < 950 || rand_pkts < 2) begin
      wait_for_results();
      if (n_phase == 0) write_expected_id(16'hffff);
      else write_expected_id(16'($urandom));
      repeat (2) begin
        add_random_packet();
        send_packet();
        rand_pkts++;
      end
      n_phase++;
    end

    // last part with no idling on either side
    wait_for_results();
    idle_en = 1'b0;
    write_expected_id(16'($urandom));
    repeat (2) begin
      add_random_packet();
      send_packet();
    end

    wait_for_results();
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/dnsrap_pkg.sv
rtl/dnsrap_in_stage.sv
rtl/dnsrap_parser.sv
rtl/dnsrap_out_stage.sv
rtl/dns_response_address_parser.sv
tb/sv/dns_answer_checker.sv
tb/sv/dns_response_address_parser_tb.sv
